[design/elfhp_pkg.sv]
// Package for the ELF32 file header parser.
// Holds header constants, status and field codes, the state and result types,
// the offset decode for the header fields and the e_type check. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package elfhp_pkg;

   localparam logic [7:0] MAGIC0 = 8'h7f;
   localparam logic [7:0] MAGIC1 = 8'h45;
   localparam logic [7:0] MAGIC2 = 8'h4C;
   localparam logic [7:0] MAGIC3 = 8'h46;
   localparam logic [7:0] ELFCLASS32 = 8'd1;
   localparam logic [7:0] ELFDATA2LSB = 8'd1;
   localparam logic [7:0] ELFDATA2MSB = 8'd2;
   localparam logic [7:0] ELF_VERSION_CUR = 8'd1;

   localparam logic [15:0] ET_NONE = 16'h0000;
   localparam logic [15:0] ET_CORE = 16'h0004;
   localparam logic [15:0] ET_LOOS = 16'hfe00;
   localparam logic [15:0] ET_HIOS = 16'hfeff;
   localparam logic [15:0] ET_PROC_LOW = 16'hff00;
   localparam logic [15:0] EM_386 = 16'd3;

   // Offsets of the identification bytes that are checked.
   localparam logic [5:0] OFF_MAG0 = 6'd0;
   localparam logic [5:0] OFF_MAG1 = 6'd1;
   localparam logic [5:0] OFF_MAG2 = 6'd2;
   localparam logic [5:0] OFF_MAG3 = 6'd3;
   localparam logic [5:0] OFF_CLASS = 6'd4;
   localparam logic [5:0] OFF_DATA = 6'd5;
   localparam logic [5:0] OFF_VERSION = 6'd6;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_MAGIC      = 4'd1,
      ST_CLASS      = 4'd2,
      ST_BYTE_ORDER = 4'd3,
      ST_VERSION    = 4'd4,
      ST_NO_TYPE    = 4'd5,
      ST_UNKNOWN    = 4'd6,
      ST_OS         = 4'd7,
      ST_PROC       = 4'd8,
      ST_MACHINE    = 4'd9
   } status_type;

   typedef enum logic [3:0] {
      FID_TYPE      = 4'd0,
      FID_MACHINE   = 4'd1,
      FID_ENTRY     = 4'd2,
      FID_PHOFF     = 4'd3,
      FID_SHOFF     = 4'd4,
      FID_FLAGS     = 4'd5,
      FID_EHSIZE    = 4'd6,
      FID_PHENTSIZE = 4'd7,
      FID_PHNUM     = 4'd8,
      FID_SHENTSIZE = 4'd9,
      FID_SHNUM     = 4'd10,
      FID_SHSTRNDX  = 4'd11
   } field_id_type;

   typedef struct packed {
      logic [5:0]  offset;
      logic        big_endian;
      logic [31:0] accum;
      logic        stopped;
   } parse_state_type;

   typedef struct packed {
      field_id_type id;
      logic [31:0]  value;
      status_type   status;
      logic         done;
   } result_type;

   typedef struct packed {
      logic         hit;
      field_id_type id;
      logic [1:0]   pos;
      logic         last;
   } field_slot_type;

   // Maps a header offset to the field that owns it and the byte's place in it.
   function automatic field_slot_type field_slot(input logic [5:0] off);
      field_slot_type slot;
      logic [5:0]     start;
      logic [5:0]     rel;
      logic           wide;
      slot  = '{hit: 1'b1, id: FID_TYPE, pos: 2'd0, last: 1'b0};
      start = 6'd16;
      wide  = 1'b0;
      case (off)
         6'd16, 6'd17: begin
            slot.id = FID_TYPE; start = 6'd16;
         end
         6'd18, 6'd19: begin
            slot.id = FID_MACHINE; start = 6'd18;
         end
         6'd24, 6'd25, 6'd26, 6'd27: begin
            slot.id = FID_ENTRY; start = 6'd24; wide = 1'b1;
         end
         6'd28, 6'd29, 6'd30, 6'd31: begin
            slot.id = FID_PHOFF; start = 6'd28; wide = 1'b1;
         end
         6'd32, 6'd33, 6'd34, 6'd35: begin
            slot.id = FID_SHOFF; start = 6'd32; wide = 1'b1;
         end
         6'd36, 6'd37, 6'd38, 6'd39: begin
            slot.id = FID_FLAGS; start = 6'd36; wide = 1'b1;
         end
         6'd40, 6'd41: begin
            slot.id = FID_EHSIZE; start = 6'd40;
         end
         6'd42, 6'd43: begin
            slot.id = FID_PHENTSIZE; start = 6'd42;
         end
         6'd44, 6'd45: begin
            slot.id = FID_PHNUM; start = 6'd44;
         end
         6'd46, 6'd47: begin
            slot.id = FID_SHENTSIZE; start = 6'd46;
         end
         6'd48, 6'd49: begin
            slot.id = FID_SHNUM; start = 6'd48;
         end
         6'd50, 6'd51: begin
            slot.id = FID_SHSTRNDX; start = 6'd50;
         end
         default: begin
            slot.hit = 1'b0;
         end
      endcase
      rel       = off - start;
      slot.pos  = rel[1:0];
      slot.last = wide ? (rel[1:0] == 2'd3) : (rel[1:0] == 2'd1);
      return slot;
   endfunction

   function automatic status_type type_status(input logic [15:0] t);
      status_type st;
      if (t == ET_NONE) begin
         st = ST_NO_TYPE;
      end else if (t > ET_CORE && t < ET_LOOS) begin
         st = ST_UNKNOWN;
      end else if (t >= ET_LOOS && t <= ET_HIOS) begin
         st = ST_OS;
      end else if (t >= ET_PROC_LOW) begin
         st = ST_PROC;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

endpackage

`default_nettype wire

[design/elfhp_req_if.sv]
// Input channel of the ELF32 header parser: one header byte per transfer.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface elfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

[design/elfhp_rsp_if.sv]
// Result channel of the ELF32 header parser: one decoded field per transfer.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface elfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_id;
   logic [31:0] field_value;
   logic [3:0]  status;
   logic        done_res;

   modport source (output valid, output field_id, output field_value, output status,
                   output done_res, input ready);
   modport sink (input valid, input field_id, input field_value, input status,
                 input done_res, output ready);
endinterface

`default_nettype wire

[design/elfhp_step.sv]
// Next-state and result logic of the ELF32 header parser for one input byte.
// Purely combinational; uses elfhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elfhp_step (
   input  elfhp_pkg::parse_state_type cur,
   input  logic [7:0]                 data_byte,
   input  logic                       start_of_file,
   input  logic [15:0]                expected_machine,
   output elfhp_pkg::parse_state_type nxt,
   output logic                       res_valid,
   output elfhp_pkg::result_type      res
);

   elfhp_pkg::parse_state_type eff;
   elfhp_pkg::field_slot_type  slot;
   elfhp_pkg::status_type      tstat;
   logic [31:0]                acc;
   logic [31:0]                base;

   always_comb begin
      eff = cur;
      if (start_of_file) begin
         eff.offset     = '0;
         eff.big_endian = 1'b0;
         eff.accum      = '0;
         eff.stopped    = 1'b0;
      end

      slot  = elfhp_pkg::field_slot(eff.offset);
      base  = (slot.pos == 2'd0) ? 32'd0 : eff.accum;
      if (eff.big_endian) begin
         acc = {base[23:0], data_byte};
      end else begin
         acc = base | ({24'd0, data_byte} << {slot.pos, 3'b000});
      end
      tstat = elfhp_pkg::type_status(acc[15:0]);

      nxt       = eff;
      res_valid = 1'b0;
      res       = '{id: elfhp_pkg::FID_TYPE, value: {24'd0, data_byte},
                    status: elfhp_pkg::ST_OK, done: 1'b1};

      if (!eff.stopped) begin
         nxt.offset = eff.offset + 6'd1;
         case (eff.offset)
            elfhp_pkg::OFF_MAG0: begin
               if (data_byte != elfhp_pkg::MAGIC0) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_MAGIC;
               end
            end
            elfhp_pkg::OFF_MAG1: begin
               if (data_byte != elfhp_pkg::MAGIC1) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_MAGIC;
               end
            end
            elfhp_pkg::OFF_MAG2: begin
               if (data_byte != elfhp_pkg::MAGIC2) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_MAGIC;
               end
            end
            elfhp_pkg::OFF_MAG3: begin
               if (data_byte != elfhp_pkg::MAGIC3) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_MAGIC;
               end
            end
            elfhp_pkg::OFF_CLASS: begin
               if (data_byte != elfhp_pkg::ELFCLASS32) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_CLASS;
               end
            end
            elfhp_pkg::OFF_DATA: begin
               if (data_byte == elfhp_pkg::ELFDATA2LSB) begin
                  nxt.big_endian = 1'b0;
               end else if (data_byte == elfhp_pkg::ELFDATA2MSB) begin
                  nxt.big_endian = 1'b1;
               end else begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_BYTE_ORDER;
               end
            end
            elfhp_pkg::OFF_VERSION: begin
               if (data_byte != elfhp_pkg::ELF_VERSION_CUR) begin
                  res_valid = 1'b1; res.status = elfhp_pkg::ST_VERSION;
               end
            end
            default: begin
               // Padding bytes and the e_version word fall through with no hit.
               if (slot.hit) begin
                  nxt.accum = acc;
                  if (slot.last) begin
                     res_valid = 1'b1;
                     res.id    = slot.id;
                     res.value = acc;
                     res.done  = 1'b0;
                     if (slot.id == elfhp_pkg::FID_TYPE) begin
                        if (tstat != elfhp_pkg::ST_OK) begin
                           res.status = tstat;
                           res.done   = 1'b1;
                        end
                     end else if (slot.id == elfhp_pkg::FID_MACHINE) begin
                        if (acc != {16'd0, expected_machine}) begin
                           res.status = elfhp_pkg::ST_MACHINE;
                           res.done   = 1'b1;
                        end
                     end else if (slot.id == elfhp_pkg::FID_SHSTRNDX) begin
                        res.done = 1'b1;
                     end
                  end
               end
            end
         endcase
         // Any error and the final field both park the parser until a new file.
         if (res_valid && res.done) begin
            nxt.stopped = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[design/elf32_header_parser.sv]
// Path: a byte taken sits in the input register and its result, if it causes one,
// moves into the result register once that register is free.
// Throughput: one byte per cycle while results drain; a result that waits on the
// output holds the input register, and the input stalls once that is full too.
// Reset: synchronous; the parser waits for a start of file and the expected
// machine code returns to Intel 386. Uses elfhp_pkg, elfhp_step, elfhp_req_if, elfhp_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module elf32_header_parser (
   input  logic               clock,
   input  logic               reset,
   elfhp_req_if.sink          req_ch,
   elfhp_rsp_if.source        rsp_ch,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff, in_byte_in;
   logic                       in_sof_ff, in_sof_in;
   logic                       out_valid_ff, out_valid_in;
   elfhp_pkg::result_type      out_res_ff, out_res_in;
   elfhp_pkg::parse_state_type state_ff, state_in;
   logic [15:0]                machine_ff, machine_in;

   elfhp_pkg::parse_state_type step_nxt;
   logic                       step_res_valid;
   elfhp_pkg::result_type      step_res;
   logic                       out_free;
   logic                       s1_fire;

   elfhp_step u_step (
      .cur              (state_ff),
      .data_byte        (in_byte_ff),
      .start_of_file    (in_sof_ff),
      .expected_machine (machine_ff),
      .nxt              (step_nxt),
      .res_valid        (step_res_valid),
      .res              (step_res)
   );

   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign s1_fire       = in_valid_ff && out_free;
   assign req_ch.ready  = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_sof_in    = in_sof_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         in_byte_in  = req_ch.data_byte;
         in_sof_in   = req_ch.start_of_file;
      end

      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_free) begin
         out_valid_in = s1_fire && step_res_valid;
         out_res_in   = step_res;
      end

      state_in   = s1_fire ? step_nxt : state_ff;
      machine_in = csr_wr_en ? csr_wr_data : machine_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{offset: 6'd0, big_endian: 1'b0, accum: 32'd0, stopped: 1'b1};
         machine_ff   <= elfhp_pkg::EM_386;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         machine_ff   <= machine_in;
      end
      in_byte_ff <= in_byte_in;
      in_sof_ff  <= in_sof_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.field_id    = out_res_ff.id;
   assign rsp_ch.field_value = out_res_ff.value;
   assign rsp_ch.status      = out_res_ff.status;
   assign rsp_ch.done_res    = out_res_ff.done;

   // Any error status must close the header.
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status != elfhp_pkg::ST_OK |-> out_res_ff.done)
      else $error("error result without done");

   // A clean finish only comes with the section name index field.
   a_clean_done_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.done && out_res_ff.status == elfhp_pkg::ST_OK
      |-> out_res_ff.id == elfhp_pkg::FID_SHSTRNDX)
      else $error("clean done on a field other than shstrndx");

   // A machine mismatch is reported on the machine field.
   a_machine_id: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status == elfhp_pkg::ST_MACHINE
      |-> out_res_ff.id == elfhp_pkg::FID_MACHINE)
      else $error("machine error on wrong field");

   // Once a header has closed, the parser waits for the next start of file.
   a_stop_after_done: assert property (@(posedge clock) disable iff (reset)
      s1_fire && step_res_valid && step_res.done |=> state_ff.stopped)
      else $error("parser still running after done");

   // A byte processed while stopped and without start of file leaves no result.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      s1_fire && state_ff.stopped && !in_sof_ff |=> !out_valid_ff)
      else $error("result produced while stopped");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for elf32_header_parser: a clocked driver sends header bytes from
// a queue, an in-bench decoder predicts every field, and a clocked monitor checks them.
// Depends on elfhp_pkg, elfhp_req_if, elfhp_rsp_if and the parser itself.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 250;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       sof;
   } header_byte_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   elfhp_req_if req_bus ();
   elfhp_rsp_if rsp_bus ();

   elf32_header_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   header_byte_type       byte_q[$];
   header_byte_type       drv_byte;
   elfhp_pkg::result_type field_q[$];
   int unsigned  errors = 0;
   int unsigned  cycles = 0;
   int unsigned  hold_cnt = 0;
   bit           hold_req = 1'b0;
   bit           hold_seen = 1'b0;
   bit           calm = 1'b0;

   // Decoder state, kept apart from the block's own.
   logic [5:0]  dec_off = '0;
   logic        dec_big = 1'b0;
   logic [31:0] dec_acc = '0;
   logic        dec_stopped = 1'b1;
   logic [15:0] want_machine = elfhp_pkg::EM_386;

   logic [7:0] hdr [52];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic elfhp_pkg::status_type classify_type(input logic [15:0] t);
      if (t == elfhp_pkg::ET_NONE) return elfhp_pkg::ST_NO_TYPE;
      if (t <= elfhp_pkg::ET_CORE) return elfhp_pkg::ST_OK;
      if (t < elfhp_pkg::ET_LOOS) return elfhp_pkg::ST_UNKNOWN;
      if (t <= elfhp_pkg::ET_HIOS) return elfhp_pkg::ST_OS;
      return elfhp_pkg::ST_PROC;
   endfunction

   // Advances the decoder by one accepted byte; returns 1 when a result comes out.
   function automatic bit decode_byte(input header_byte_type hb,
                                      output elfhp_pkg::result_type r);
      logic [5:0] off;
      logic [5:0] base;
      logic [5:0] k;
      int         len;
      int         idx;
      bit         ok;
      elfhp_pkg::status_type   st;
      elfhp_pkg::field_id_type fid;
      r = '{id: elfhp_pkg::FID_TYPE, value: '0, status: elfhp_pkg::ST_OK, done: 1'b0};
      if (hb.sof) begin
         dec_stopped = 1'b0;
         dec_off     = '0;
         dec_big     = 1'b0;
         dec_acc     = '0;
      end
      if (dec_stopped) return 1'b0;
      off     = dec_off;
      dec_off = dec_off + 6'd1;

      if (off <= elfhp_pkg::OFF_VERSION) begin
         ok = 1'b1;
         st = elfhp_pkg::ST_MAGIC;
         case (off)
            elfhp_pkg::OFF_MAG0: ok = (hb.data == elfhp_pkg::MAGIC0);
            elfhp_pkg::OFF_MAG1: ok = (hb.data == elfhp_pkg::MAGIC1);
            elfhp_pkg::OFF_MAG2: ok = (hb.data == elfhp_pkg::MAGIC2);
            elfhp_pkg::OFF_MAG3: ok = (hb.data == elfhp_pkg::MAGIC3);
            elfhp_pkg::OFF_CLASS: begin
               ok = (hb.data == elfhp_pkg::ELFCLASS32);
               st = elfhp_pkg::ST_CLASS;
            end
            elfhp_pkg::OFF_DATA: begin
               ok = (hb.data == elfhp_pkg::ELFDATA2LSB) ||
                    (hb.data == elfhp_pkg::ELFDATA2MSB);
               dec_big = (hb.data == elfhp_pkg::ELFDATA2MSB);
               st = elfhp_pkg::ST_BYTE_ORDER;
            end
            default: begin
               ok = (hb.data == elfhp_pkg::ELF_VERSION_CUR);
               st = elfhp_pkg::ST_VERSION;
            end
         endcase
         if (ok) return 1'b0;
         dec_stopped = 1'b1;
         r.value  = {24'h0, hb.data};
         r.status = st;
         r.done   = 1'b1;
         return 1'b1;
      end

      if (off >= 6'd16 && off < 6'd20) begin
         idx = (off - 16) / 2;
         fid = elfhp_pkg::field_id_type'(idx);
         base = 6'(16 + 2 * idx);
         len = 2;
      end else if (off >= 6'd24 && off < 6'd40) begin
         idx = (off - 24) / 4;
         fid = elfhp_pkg::field_id_type'(2 + idx);
         base = 6'(24 + 4 * idx);
         len = 4;
      end else if (off >= 6'd40 && off < 6'd52) begin
         idx = (off - 40) / 2;
         fid = elfhp_pkg::field_id_type'(6 + idx);
         base = 6'(40 + 2 * idx);
         len = 2;
      end else begin
         return 1'b0;
      end

      k = off - base;
      if (k == 0) dec_acc = '0;
      if (dec_big) dec_acc = {dec_acc[23:0], hb.data};
      else dec_acc = dec_acc | ({24'h0, hb.data} << (8 * k));
      if (int'(k) + 1 != len) return 1'b0;

      r.id    = fid;
      r.value = dec_acc;
      if (fid == elfhp_pkg::FID_TYPE) begin
         r.status = classify_type(dec_acc[15:0]);
      end else if (fid == elfhp_pkg::FID_MACHINE && dec_acc != {16'h0, want_machine}) begin
         r.status = elfhp_pkg::ST_MACHINE;
      end
      if (r.status != elfhp_pkg::ST_OK || fid == elfhp_pkg::FID_SHSTRNDX) begin
         dec_stopped = 1'b1;
         r.done = 1'b1;
      end
      return 1'b1;
   endfunction

   // Driver: a transfer happens where valid and ready were both high before the edge.
   always @(posedge clock) begin
      elfhp_pkg::result_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (decode_byte(drv_byte, r)) field_q.push_back(r);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
               drv_byte = byte_q.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.data_byte     <= drv_byte.data;
               req_bus.start_of_file <= drv_byte.sof;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, so the parser backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_req && !hold_seen) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_seen <= 1'b1;
      end
   end

   // Monitor: compares each result transfer with the oldest predicted field.
   always @(posedge clock) begin
      elfhp_pkg::result_type r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (field_q.size() == 0) begin
               $error("unexpected result: field_id %0d value %0h status %0d done %0b",
                      rsp_bus.field_id, rsp_bus.field_value, rsp_bus.status,
                      rsp_bus.done_res);
               errors++;
            end else begin
               r = field_q.pop_front();
               if (rsp_bus.field_id !== r.id) begin
                  $error("field_id: expected %0d, actual %0d", r.id, rsp_bus.field_id);
                  errors++;
               end
               if (rsp_bus.field_value !== r.value) begin
                  $error("field_value: expected %0h, actual %0h", r.value,
                         rsp_bus.field_value);
                  errors++;
               end
               if (rsp_bus.status !== r.status) begin
                  $error("status: expected %0d, actual %0d", r.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.done_res !== r.done) begin
                  $error("done_res: expected %0b, actual %0b", r.done, rsp_bus.done_res);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 26);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("elf32_header_parser: mismatch");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic sof);
      byte_q.push_back('{data: data, sof: sof});
   endtask

   task automatic place_field(input int base, input int len, input logic [31:0] v,
                              input bit big);
      for (int i = 0; i < len; i++) begin
         hdr[base + i] = big ? v[8 * (len - 1 - i) +: 8] : v[8 * i +: 8];
      end
   endtask

   function automatic logic [15:0] pick_type();
      case ($urandom_range(29))
         0: return elfhp_pkg::ET_NONE;
         1: return 16'h0005;
         2: return 16'($urandom_range(5, 16'hfdff));
         3: return 16'hfdff;
         4: return elfhp_pkg::ET_LOOS;
         5: return 16'($urandom_range(elfhp_pkg::ET_LOOS, elfhp_pkg::ET_HIOS));
         6: return elfhp_pkg::ET_HIOS;
         7: return elfhp_pkg::ET_PROC_LOW;
         8: return 16'($urandom_range(elfhp_pkg::ET_PROC_LOW, 16'hffff));
         9: return 16'hffff;
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   // Sends one header; bad_at spoils one ident byte, cut stops early (0 sends all).
   task automatic send_header(input bit big, input logic [15:0] etype,
                              input logic [15:0] mach, input int bad_at, input int cut,
                              inout int sent);
      logic [7:0] good;
      logic [7:0] wrong;
      int n;
      for (int i = 0; i < 52; i++) hdr[i] = 8'($urandom_range(255));
      hdr[0] = elfhp_pkg::MAGIC0;
      hdr[1] = elfhp_pkg::MAGIC1;
      hdr[2] = elfhp_pkg::MAGIC2;
      hdr[3] = elfhp_pkg::MAGIC3;
      hdr[4] = elfhp_pkg::ELFCLASS32;
      hdr[5] = big ? elfhp_pkg::ELFDATA2MSB : elfhp_pkg::ELFDATA2LSB;
      hdr[6] = elfhp_pkg::ELF_VERSION_CUR;
      if ($urandom_range(19) == 0) begin
         good = $urandom_range(1) ? 8'hff : 8'h00;
         for (int i = 24; i < 52; i++) hdr[i] = good;
      end
      place_field(16, 2, {16'h0, etype}, big);
      place_field(18, 2, {16'h0, mach}, big);
      n = (cut > 0) ? cut : 52;
      if (bad_at >= 0) begin
         good = hdr[bad_at];
         do begin
            wrong = 8'($urandom_range(255));
         end while (wrong == good ||
                    (bad_at == elfhp_pkg::OFF_DATA &&
                     (wrong == elfhp_pkg::ELFDATA2LSB || wrong == elfhp_pkg::ELFDATA2MSB)));
         hdr[bad_at] = wrong;
         n = bad_at + 1;
      end
      for (int i = 0; i < n; i++) push_byte(hdr[i], i == 0);
      sent += n;
   endtask

   task automatic random_traffic(inout int sent);
      int pick;
      int n;
      logic [15:0] mach;
      pick = $urandom_range(99);
      mach = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hffff)) : want_machine;
      if (pick < 60) begin
         send_header($urandom_range(1), pick_type(), mach, -1, 0, sent);
      end else if (pick < 72) begin
         send_header($urandom_range(1), pick_type(), mach, $urandom_range(6), 0, sent);
      end else if (pick < 84) begin
         send_header($urandom_range(1), pick_type(), mach, -1, $urandom_range(1, 51), sent);
      end else if (pick < 92) begin
         // Stray bytes with no start of file; mostly ignored.
         n = $urandom_range(1, 6);
         repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
         sent += n;
      end
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_bus.valid || field_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] settings [5];
      int sent;
      settings[0] = elfhp_pkg::EM_386;
      settings[1] = 16'h0000;
      settings[2] = 16'hffff;
      settings[3] = 16'($urandom_range(16'hffff));
      settings[4] = 16'h0028;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.start_of_file = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_drained();
            repeat (4) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= settings[ph];
            want_machine = settings[ph];
            @(posedge clock);
            csr_wr_en <= 1'b0;
         end
         @(negedge clock);
         if (ph == 0) begin
            // A byte with no start of file while waiting is dropped.
            push_byte(elfhp_pkg::MAGIC0, 1'b0);
            push_byte(8'hff, 1'b1);
            push_byte(elfhp_pkg::MAGIC0, 1'b1);
            push_byte(8'h00, 1'b0);
            push_byte(elfhp_pkg::MAGIC0, 1'b1);
            push_byte(elfhp_pkg::MAGIC1, 1'b0);
            push_byte(elfhp_pkg::MAGIC2, 1'b0);
            push_byte(elfhp_pkg::MAGIC3, 1'b0);
            push_byte(8'h00, 1'b0);
            // Headers that fail on the byte order and then on the version.
            push_byte(elfhp_pkg::MAGIC0, 1'b1);
            push_byte(elfhp_pkg::MAGIC1, 1'b0);
            push_byte(elfhp_pkg::MAGIC2, 1'b0);
            push_byte(elfhp_pkg::MAGIC3, 1'b0);
            push_byte(elfhp_pkg::ELFCLASS32, 1'b0);
            push_byte(8'h03, 1'b0);
            push_byte(elfhp_pkg::MAGIC0, 1'b1);
            push_byte(elfhp_pkg::MAGIC1, 1'b0);
            push_byte(elfhp_pkg::MAGIC2, 1'b0);
            push_byte(elfhp_pkg::MAGIC3, 1'b0);
            push_byte(elfhp_pkg::ELFCLASS32, 1'b0);
            push_byte(elfhp_pkg::ELFDATA2MSB, 1'b0);
            push_byte(8'h02, 1'b0);
         end
         if (ph == 1) begin
            calm = 1'b1;
            hold_req = 1'b1;
         end
         if (ph == 2) calm = 1'b0;
         sent = 0;
         while (sent < PHASE_BYTES) random_traffic(sent);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("elf32_header_parser: match");
      end else begin
         $display("elf32_header_parser: mismatch");
      end
      $finish;
   end

endmodule
